// ===== src/llse_pkg.sv =====
// Linked-list set engine: shared constants, codes, state and command types.
// No dependencies; every other file of the block imports this package.
package llse_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF  = 32;
  localparam int unsigned OPCODE_BITS   = 2;
  localparam int unsigned KEY_PORT_BITS = 32;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned COUNT_BITS    = 5;

  // Opcode 3 is unused and answers a miss.
  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_UNLINK,
    S_FREE,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_FREE
  } rd_sel_e;

  typedef struct packed {
    logic    start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    step;
    logic    hit_take;
    logic    alloc_wr;
    logic    unlink_wr;
    logic    free_wr;
    logic    set_res;
    status_e res_code;
    logic    load_out;
  } llse_cmd_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] op;
    logic                   op_valid;
    logic                   cur_null;
    logic                   key_hit;
    logic                   walk_last;
    logic                   full;
    logic                   out_free;
  } llse_sts_t;

endpackage

// ===== src/llse_if.sv =====
// Linked-list set engine: request and result channel interfaces.
// Valid/ready handshake; widths come from llse_pkg.
interface llse_req_if;
  import llse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_BITS-1:0]   opcode;
  logic [KEY_PORT_BITS-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface llse_res_if;
  import llse_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  count;
  logic                   empty_res;

  modport source (output valid, output status, output count, output empty_res, input ready);
  modport sink (input valid, input status, input count, input empty_res, output ready);
endinterface

// ===== src/llse_ctrl.sv =====
// Linked-list set engine: controller state machine.
// Drives the datapath through llse_pkg::llse_cmd_t, reads llse_pkg::llse_sts_t.
module llse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llse_pkg::llse_sts_t sts_i,
  output llse_pkg::llse_cmd_t cmd_o
);
  import llse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start  = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HEAD;
          state_d      = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts_i.op_valid) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_MISS;
          state_d        = S_RESP;
        end else if (!sts_i.cur_null && sts_i.key_hit) begin
          if (sts_i.op == OP_ADD) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = RES_MISS;
            state_d        = S_RESP;
          end else if (sts_i.op == OP_REMOVE) begin
            cmd_o.hit_take = 1'b1;
            state_d        = S_UNLINK;
          end else begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = RES_OK;
            state_d        = S_RESP;
          end
        end else if (!sts_i.cur_null && !sts_i.walk_last) begin
          // advance to the successor slot
          cmd_o.step   = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
        end else if (sts_i.op == OP_ADD) begin
          if (sts_i.full) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = RES_FULL;
            state_d        = S_RESP;
          end else begin
            // fetch the free head's successor for the pop
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_FREE;
            state_d      = S_ALLOC;
          end
        end else begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_MISS;
          state_d        = S_RESP;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_wr = 1'b1;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = RES_OK;
        state_d        = S_RESP;
      end
      S_UNLINK: begin
        cmd_o.unlink_wr = 1'b1;
        state_d         = S_FREE;
      end
      S_FREE: begin
        cmd_o.free_wr  = 1'b1;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = RES_OK;
        state_d        = S_RESP;
      end
      S_RESP: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_alloc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc_wr |-> !sts_i.full)
    else $error("slot allocated while set is full");

  a_load_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> $past(state_q) != S_IDLE)
    else $error("result loaded straight after idle");

endmodule

// ===== src/llse_dp.sv =====
// Linked-list set engine: datapath with key and link memories, list heads,
// element count and output register. Uses llse_pkg command and status types.
module llse_dp #(
  parameter int unsigned CAPACITY = llse_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = llse_pkg::KEY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  llse_pkg::llse_cmd_t                 cmd_i,
  output llse_pkg::llse_sts_t                 sts_o,
  input  logic [llse_pkg::OPCODE_BITS-1:0]    in_opcode_i,
  input  logic [llse_pkg::KEY_PORT_BITS-1:0]  in_key_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [llse_pkg::STATUS_BITS-1:0]    out_status_o,
  output logic [llse_pkg::COUNT_BITS-1:0]     out_count_o,
  output logic                                out_empty_o
);
  import llse_pkg::*;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned LINK_W = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned STEP_W = $clog2(CAPACITY);
  localparam int unsigned KW     = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int unsigned OW     = (CNT_W < COUNT_BITS) ? CNT_W : COUNT_BITS;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);

  logic [KEY_BITS-1:0] key_mem_q  [CAPACITY];
  logic [LINK_W-1:0]   link_mem_q [CAPACITY];

  logic [KEY_BITS-1:0]    key_q;
  logic [OPCODE_BITS-1:0] op_q;
  logic [KEY_BITS-1:0]    key_rdata_q;
  logic [LINK_W-1:0]      link_rdata_q;
  logic [LINK_W-1:0]      cur_q, prev_q, hit_next_q;
  logic [STEP_W-1:0]      steps_q;
  logic [LINK_W-1:0]      list_head_q, list_head_d;
  logic [LINK_W-1:0]      free_head_q, free_head_d;
  logic [LINK_W-1:0]      fresh_q, fresh_d;
  logic [CNT_W-1:0]       count_q, count_d;
  status_e                res_q;
  logic                   out_valid_q;
  logic [STATUS_BITS-1:0] out_status_q;
  logic [COUNT_BITS-1:0]  out_count_q;
  logic                   out_empty_q;

  logic [LINK_W-1:0] rd_link, link_val, wr_link_data;
  logic [SLOT_W-1:0] wr_link_slot;
  logic              wr_link_en;

  // Slots at or above the fresh mark were never written: their link is
  // still the reset chain, so the successor is the next slot number.
  assign link_val = (cur_q >= fresh_q) ? (cur_q + LINK_W'(1)) : link_rdata_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD: rd_link = list_head_q;
      RD_NEXT: rd_link = link_val;
      RD_FREE: rd_link = free_head_q;
      default: rd_link = list_head_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      key_rdata_q  <= key_mem_q[rd_link[SLOT_W-1:0]];
      link_rdata_q <= link_mem_q[rd_link[SLOT_W-1:0]];
    end
    if (cmd_i.alloc_wr) begin
      key_mem_q[free_head_q[SLOT_W-1:0]] <= key_q;
    end
    if (wr_link_en) begin
      link_mem_q[wr_link_slot] <= wr_link_data;
    end
  end

  always_comb begin
    wr_link_en   = 1'b0;
    wr_link_slot = free_head_q[SLOT_W-1:0];
    wr_link_data = list_head_q;
    if (cmd_i.alloc_wr) begin
      wr_link_en = 1'b1;
    end else if (cmd_i.unlink_wr && (prev_q < NULL_LINK)) begin
      wr_link_en   = 1'b1;
      wr_link_slot = prev_q[SLOT_W-1:0];
      wr_link_data = hit_next_q;
    end else if (cmd_i.free_wr) begin
      wr_link_en   = 1'b1;
      wr_link_slot = cur_q[SLOT_W-1:0];
      wr_link_data = free_head_q;
    end
  end

  // Walk registers and the latched request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q   <= KEY_BITS'(in_key_i[KW-1:0]);
      op_q    <= in_opcode_i;
      prev_q  <= NULL_LINK;
      steps_q <= '0;
    end else if (cmd_i.step) begin
      prev_q  <= cur_q;
      steps_q <= steps_q + STEP_W'(1);
    end
    if (cmd_i.rd_en) begin
      cur_q <= rd_link;
    end
    if (cmd_i.hit_take) begin
      hit_next_q <= link_val;
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_q;
      out_count_q  <= COUNT_BITS'(count_q[OW-1:0]);
      out_empty_q  <= (count_q == '0);
    end
  end

  always_comb begin
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    if (cmd_i.alloc_wr) begin
      list_head_d = free_head_q;
      free_head_d = link_val;
      count_d     = count_q + CNT_W'(1);
      if (free_head_q == fresh_q) begin
        fresh_d = fresh_q + LINK_W'(1);
      end
    end
    if (cmd_i.unlink_wr && !(prev_q < NULL_LINK)) begin
      list_head_d = hit_next_q;
    end
    if (cmd_i.free_wr) begin
      free_head_d = cur_q;
      if (count_q != '0) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_head_q <= NULL_LINK;
      free_head_q <= '0;
      fresh_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.op_valid  = (op_q == OP_ADD) || (op_q == OP_REMOVE) || (op_q == OP_SEARCH);
  assign sts_o.cur_null  = !(cur_q < NULL_LINK);
  assign sts_o.key_hit   = (key_rdata_q == key_q);
  assign sts_o.walk_last = (steps_q == STEP_LAST) || !(link_val < NULL_LINK);
  assign sts_o.full      = (count_q >= CNT_FULL) || !(free_head_q < NULL_LINK);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_empty_o  = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("element count above capacity");

  a_full_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_FULL) |-> !(free_head_q < NULL_LINK))
    else $error("free list not empty while set is full");

  a_heads_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_head_q < NULL_LINK) |-> (list_head_q != free_head_q))
    else $error("set list and free list share a head slot");

endmodule

// ===== src/linked_list_set_engine.sv =====
// Linked-list set engine top level: wires the controller to the datapath.
// Depends on llse_pkg, llse_if, llse_ctrl and llse_dp.
//
// Holds up to CAPACITY distinct keys as a singly linked list threaded through
// a key memory and a link memory, with unused slots on a free list. One
// request is in service at a time; a request is taken only when the engine is
// idle, while an earlier result may still sit in the output register. Each
// request walks the set list one slot per clock through the registered memory
// read. After the walk a successful add passes through S_ALLOC, a successful
// remove through S_UNLINK and S_FREE, and every request ends in S_RESP, where
// its result waits until the output register is free before the engine turns
// idle again. The link memory needs no clearing pass after reset; a fill mark
// stands in for the initial free chain.
module linked_list_set_engine #(
  parameter int unsigned CAPACITY = llse_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = llse_pkg::KEY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llse_req_if.sink   in_i,
  llse_res_if.source out_o
);
  import llse_pkg::*;

  llse_cmd_t cmd;
  llse_sts_t sts;

  llse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  llse_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_opcode_i  (in_i.opcode),
    .in_key_i     (in_i.key),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.count),
    .out_empty_o  (out_o.empty_res)
  );

endmodule

// ===== test/tb_linked_list_set_engine.sv =====
// Testbench for linked_list_set_engine: drives add/remove/search requests and checks
// every result against an in-bench model of the slot arrays and free list.
// Depends on llse_pkg, llse_if and the engine RTL.
module tb_linked_list_set_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import llse_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int NIL   = CAPACITY_DEF;
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]   op;
    logic [KEY_PORT_BITS-1:0] key;
  } set_req_t;

  typedef struct packed {
    status_e               status;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } set_result_t;

  logic clk_i;
  logic rst_ni;

  llse_req_if req_ch ();
  llse_res_if res_ch ();

  linked_list_set_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (res_ch.source)
  );

  // Mirror of the engine's slot arrays
  logic [KEY_PORT_BITS-1:0] held_keys [SLOTS];
  int                       slot_next [SLOTS];
  int                       set_head;
  int                       free_slot_head;
  int                       held_count;

  set_req_t    pending_reqs[$];
  set_result_t expected_results[$];

  int n_queued;
  int n_accepted;
  int n_errors;
  int send_idle_pct;
  int recv_stall_pct;

  function automatic set_result_t apply_set_op(logic [OPCODE_BITS-1:0] op,
                                               logic [KEY_PORT_BITS-1:0] key);
    int          cur;
    int          prev;
    int          hit;
    int          steps;
    int          s;
    set_result_t r;
    cur   = set_head;
    prev  = NIL;
    hit   = NIL;
    steps = 0;
    r.status = RES_MISS;
    // Walk at most SLOTS entries; any out-of-range link ends the walk
    while (steps < SLOTS && cur < SLOTS && hit == NIL) begin
      if (held_keys[cur] == key) begin
        hit = cur;
      end else begin
        prev = cur;
        cur  = slot_next[cur];
      end
      steps++;
    end
    if (hit == NIL) prev = NIL;
    case (op)
      OP_ADD: begin
        if (hit != NIL) begin
          r.status = RES_MISS;
        end else if (held_count >= SLOTS || free_slot_head >= SLOTS) begin
          r.status = RES_FULL;
        end else begin
          s              = free_slot_head;
          free_slot_head = slot_next[s];
          held_keys[s]   = key;
          slot_next[s]   = set_head;
          set_head       = s;
          held_count++;
          r.status = RES_OK;
        end
      end
      OP_REMOVE: begin
        if (hit != NIL) begin
          if (prev != NIL) slot_next[prev] = slot_next[hit];
          else set_head = slot_next[hit];
          slot_next[hit] = free_slot_head;
          free_slot_head = hit;
          if (held_count > 0) held_count--;
          r.status = RES_OK;
        end
      end
      OP_SEARCH: r.status = (hit != NIL) ? RES_OK : RES_MISS;
      default:   r.status = RES_MISS;
    endcase
    r.count = held_count[COUNT_BITS-1:0];
    r.empty = (held_count == 0);
    return r;
  endfunction

  function automatic void queue_req(logic [OPCODE_BITS-1:0] op,
                                    logic [KEY_PORT_BITS-1:0] key);
    set_req_t q;
    q.op  = op;
    q.key = key;
    pending_reqs.push_back(q);
    n_queued++;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: hold each request until the engine takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= '0;
      req_ch.key    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_set_op(req_ch.opcode, req_ch.key));
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid  <= 1'b1;
          req_ch.opcode <= pending_reqs[0].op;
          req_ch.key    <= pending_reqs[0].key;
          void'(pending_reqs.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d empty=%0b", $time,
                   res_ch.status, res_ch.count, res_ch.empty_res);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     res_ch.status);
            n_errors++;
          end
          if (res_ch.count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time, want.count, res_ch.count);
            n_errors++;
          end
          if (res_ch.empty_res !== want.empty) begin
            $display("%0t: empty expected %0b, got %0b", $time, want.empty,
                     res_ch.empty_res);
            n_errors++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_linked_list_set_engine: done, errors");
    $finish;
  end

  initial begin
    logic [KEY_PORT_BITS-1:0] key_pool [24];
    logic [OPCODE_BITS-1:0]   op;
    logic [KEY_PORT_BITS-1:0] key;
    int                       r;
    int                       add_pct;
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.opcode  = '0;
    req_ch.key     = '0;
    res_ch.ready   = 1'b0;
    n_queued       = 0;
    n_accepted     = 0;
    n_errors       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) begin
      held_keys[i] = '0;
      slot_next[i] = i + 1;
    end
    set_head       = NIL;
    free_slot_head = 0;
    held_count     = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty set: misses and the unused opcode
    queue_req(OP_SEARCH, 32'd5);
    queue_req(OP_REMOVE, 32'd5);
    queue_req(OP_UNUSED, 32'd5);
    // Key extremes and a duplicate
    queue_req(OP_ADD, 32'h0000_0000);
    queue_req(OP_ADD, 32'hFFFF_FFFF);
    queue_req(OP_ADD, 32'h0000_0000);
    queue_req(OP_SEARCH, 32'hFFFF_FFFF);
    // Fill to capacity, then overflow
    for (int i = 0; i < SLOTS - 2; i++) queue_req(OP_ADD, 32'h1 << (2 * i + 1));
    queue_req(OP_ADD, 32'h1234_5678);
    queue_req(OP_ADD, 32'hFFFF_FFFF);
    queue_req(OP_UNUSED, 32'hFFFF_FFFF);
    // Unlink tail, head and a middle slot
    queue_req(OP_REMOVE, 32'h0000_0000);
    queue_req(OP_REMOVE, 32'h1 << (2 * (SLOTS - 3) + 1));
    queue_req(OP_REMOVE, 32'h1 << 9);
    queue_req(OP_SEARCH, 32'h1 << 9);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      foreach (key_pool[i]) key_pool[i] = $urandom;
      // Alternate add-heavy and remove-heavy batches to swing between full and empty
      for (int b = 0; b < 9; b++) begin
        add_pct = (b % 2 == 0) ? 60 : 25;
        for (int n = 0; n < 50; n++) begin
          r = $urandom_range(99);
          if (r < 4) op = OP_UNUSED;
          else if (r < 4 + add_pct) op = OP_ADD;
          else if ($urandom_range(1) == 0) op = OP_REMOVE;
          else op = OP_SEARCH;
          r = $urandom_range(9);
          if (r == 0) key = $urandom;
          else if (r == 1) key = key_pool[$urandom_range(23)] ^ (32'h1 << $urandom_range(31));
          else key = key_pool[$urandom_range(23)];
          queue_req(op, key);
        end
      end
      while (pending_reqs.size() != 0) @(negedge clk_i);
    end

    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("tb_linked_list_set_engine: done, clean");
    end else begin
      $display("tb_linked_list_set_engine: done, errors");
    end
    $finish;
  end

endmodule

// ===== linked_list_set_engine.f =====
src/llse_pkg.sv
src/llse_if.sv
src/llse_ctrl.sv
src/llse_dp.sv
src/linked_list_set_engine.sv
test/tb_linked_list_set_engine.sv
